/* hdl/plo_pkg.sv */
// Shared constants, types and register codes of the path length odometer.
package plo_pkg;

    localparam int POS_BITS   = 24;
    localparam int SUM_BITS   = 48;
    localparam int DEPTH_BITS = 20;
    localparam int TIME_BITS  = 32;
    localparam int DATA_BITS  = 32;
    localparam int ADDR_BITS  = 3;

    localparam int MAG_BITS = POS_BITS + 1;
    localparam int SQ_BITS  = 2 * MAG_BITS;
    localparam int CNT_BITS = $clog2(MAG_BITS);
    localparam int ACC_BITS = ((SUM_BITS > MAG_BITS) ? SUM_BITS : MAG_BITS) + 1;

    localparam logic [TIME_BITS-1:0] STALE_RESET = TIME_BITS'(10000);

    localparam logic [0:0] REG_DEPTH_THR = 1'b0;
    localparam logic [0:0] REG_STALE_LIM = 1'b1;

    typedef struct packed {
        logic load;
        logic step;
    } sq_ctrl_t;

    typedef struct packed {
        logic [DEPTH_BITS-1:0] depth_thr;
        logic [TIME_BITS-1:0]  stale_lim;
    } cfg_t;

endpackage

/* hdl/plo_in_if.sv */
// Request channel carrying one update tick.
interface plo_in_if;
    logic                                     valid;
    logic                                     ready;
    logic signed [plo_pkg::POS_BITS-1:0]      pos_x;
    logic signed [plo_pkg::POS_BITS-1:0]      pos_y;
    logic        [plo_pkg::DEPTH_BITS-1:0]    depth_now;
    logic        [plo_pkg::TIME_BITS-1:0]     fix_time;
    logic        [plo_pkg::TIME_BITS-1:0]     time_now;

    modport source (output valid, pos_x, pos_y, depth_now, fix_time, time_now, input ready);
    modport sink   (input valid, pos_x, pos_y, depth_now, fix_time, time_now, output ready);
endinterface

/* hdl/plo_out_if.sv */
// Result channel carrying the odometer readings.
interface plo_out_if;
    logic                              valid;
    logic                              ready;
    logic [plo_pkg::SUM_BITS-1:0]      total_distance;
    logic [plo_pkg::SUM_BITS-1:0]      depth_distance;
    logic                              stale;
    logic                              first_fix;

    modport source (output valid, total_distance, depth_distance, stale, first_fix, input ready);
    modport sink   (input valid, total_distance, depth_distance, stale, first_fix, output ready);
endinterface

/* hdl/plo_regs.sv */
// APB configuration registers: depth threshold and stale limit.
module plo_regs
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [plo_pkg::ADDR_BITS-1:0]  paddr,
    input  logic [plo_pkg::DATA_BITS-1:0]  pwdata,
    output logic [plo_pkg::DATA_BITS-1:0]  prdata,
    output logic                           pready,
    output plo_pkg::cfg_t                  cfg
);

    logic [plo_pkg::DEPTH_BITS-1:0] depth_thr_reg;
    logic [plo_pkg::DEPTH_BITS-1:0] depth_thr_next;
    logic [plo_pkg::TIME_BITS-1:0]  stale_lim_reg;
    logic [plo_pkg::TIME_BITS-1:0]  stale_lim_next;
    logic                           wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_comb
    begin
        depth_thr_next = depth_thr_reg;
        stale_lim_next = stale_lim_reg;
        if (wr_en)
        begin
            unique case (paddr[2])
                plo_pkg::REG_DEPTH_THR: depth_thr_next = pwdata[plo_pkg::DEPTH_BITS-1:0];
                plo_pkg::REG_STALE_LIM: stale_lim_next = pwdata[plo_pkg::TIME_BITS-1:0];
                default:                depth_thr_next = depth_thr_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            plo_pkg::REG_DEPTH_THR: prdata = plo_pkg::DATA_BITS'(depth_thr_reg);
            plo_pkg::REG_STALE_LIM: prdata = plo_pkg::DATA_BITS'(stale_lim_reg);
            default:                prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_thr_reg <= '0;
            stale_lim_reg <= plo_pkg::STALE_RESET;
        end
        else
        begin
            depth_thr_reg <= depth_thr_next;
            stale_lim_reg <= stale_lim_next;
        end
    end

    assign cfg.depth_thr = depth_thr_reg;
    assign cfg.stale_lim = stale_lim_reg;

endmodule

/* hdl/plo_square.sv */
// Bit-serial squarer: one multiplier bit per cycle while step is set, shift-add.
module plo_square
(
    input  logic                          clk,
    input  plo_pkg::sq_ctrl_t             ctrl,
    input  logic [plo_pkg::MAG_BITS-1:0]  operand,
    output logic [plo_pkg::SQ_BITS-1:0]   product
);

    logic [plo_pkg::MAG_BITS-1:0] mcand_reg;
    logic [plo_pkg::MAG_BITS-1:0] mcand_next;
    logic [plo_pkg::MAG_BITS-1:0] hi_reg;
    logic [plo_pkg::MAG_BITS-1:0] hi_next;
    logic [plo_pkg::MAG_BITS-1:0] lo_reg;
    logic [plo_pkg::MAG_BITS-1:0] lo_next;
    logic [plo_pkg::MAG_BITS:0]   part_sum;

    assign part_sum = {1'b0, hi_reg} + (lo_reg[0] ? {1'b0, mcand_reg} : '0);

    always_comb
    begin
        mcand_next = mcand_reg;
        hi_next    = hi_reg;
        lo_next    = lo_reg;
        priority if (ctrl.load)
        begin
            mcand_next = operand;
            hi_next    = '0;
            lo_next    = operand;
        end
        else if (ctrl.step)
        begin
            hi_next = part_sum[plo_pkg::MAG_BITS:1];
            lo_next = {part_sum[0], lo_reg[plo_pkg::MAG_BITS-1:1]};
        end
        else
        begin
            mcand_next = mcand_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        mcand_reg <= mcand_next;
        hi_reg    <= hi_next;
        lo_reg    <= lo_next;
    end

    assign product = {hi_reg, lo_reg};

endmodule

/* hdl/plo_isqrt.sv */
// Digit-serial integer square root: two radicand bits in, one root bit out per cycle while step is set.
module plo_isqrt
(
    input  logic                          clk,
    input  plo_pkg::sq_ctrl_t             ctrl,
    input  logic [plo_pkg::SQ_BITS-1:0]   radicand,
    output logic [plo_pkg::MAG_BITS-1:0]  root
);

    localparam int M = plo_pkg::MAG_BITS;
    localparam int S = plo_pkg::SQ_BITS;

    logic [S-1:0] rad_reg;
    logic [S-1:0] rad_next;
    logic [M:0]   rem_reg;
    logic [M:0]   rem_next;
    logic [M-1:0] root_reg;
    logic [M-1:0] root_next;
    logic [M+2:0] rem_sh;
    logic [M+2:0] trial;
    logic [M+2:0] diff;
    logic         fits;

    assign rem_sh = {rem_reg, rad_reg[S-1:S-2]};
    assign trial  = {1'b0, root_reg, 2'b01};
    assign fits   = rem_sh >= trial;
    assign diff   = rem_sh - trial;

    always_comb
    begin
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        priority if (ctrl.load)
        begin
            rad_next  = radicand;
            rem_next  = '0;
            root_next = '0;
        end
        else if (ctrl.step)
        begin
            rad_next  = {rad_reg[S-3:0], 2'b00};
            rem_next  = fits ? diff[M:0] : rem_sh[M:0];
            root_next = {root_reg[M-2:0], fits};
        end
        else
        begin
            rad_next  = rad_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign root = root_reg;

endmodule

/* hdl/path_length_odometer.sv */
// Top level of the path length odometer: tick control, accumulation and result register.
// An ordinary tick passes these steps in order: accept and take the position differences, load
// the magnitudes, square them bit-serially, add the squares, take the square root (one root
// bit per cycle) and accumulate; accumulation waits until the output register is free. The
// first tick after reset latches the position and goes straight to accumulation with a
// zero step; its result is marked first_fix. One request is worked on at a time; the result
// sits in an output register, so the next request is taken while an earlier result still waits.
// The user must write configuration over the APB port while idle; the block does not check.
module path_length_odometer
(
    input  logic                           clk,
    input  logic                           rst_n,
    plo_in_if.sink                         req,
    plo_out_if.source                      res,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [plo_pkg::ADDR_BITS-1:0]  paddr,
    input  logic [plo_pkg::DATA_BITS-1:0]  pwdata,
    output logic [plo_pkg::DATA_BITS-1:0]  prdata,
    output logic                           pready
);

    localparam int M = plo_pkg::MAG_BITS;
    localparam int P = plo_pkg::POS_BITS;
    localparam int W = plo_pkg::SUM_BITS;
    localparam int A = plo_pkg::ACC_BITS;
    localparam int T = plo_pkg::TIME_BITS;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_LOAD   = 6'b000010,
        ST_SQUARE = 6'b000100,
        ST_RLOAD  = 6'b001000,
        ST_ROOT   = 6'b010000,
        ST_ACCUM  = 6'b100000
    } state_t;

    state_t                         state_reg;
    state_t                         state_next;
    logic [plo_pkg::CNT_BITS-1:0]   cnt_reg;
    logic [plo_pkg::CNT_BITS-1:0]   cnt_next;

    logic signed [P-1:0]            prev_x_reg;
    logic signed [P-1:0]            prev_x_next;
    logic signed [P-1:0]            prev_y_reg;
    logic signed [P-1:0]            prev_y_next;
    logic                           awaiting_reg;
    logic                           awaiting_next;
    logic [W-1:0]                   path_sum_reg;
    logic [W-1:0]                   path_sum_next;
    logic [W-1:0]                   deep_sum_reg;
    logic [W-1:0]                   deep_sum_next;

    logic [M-1:0]                   dx_reg;
    logic [M-1:0]                   dx_next;
    logic [M-1:0]                   dy_reg;
    logic [M-1:0]                   dy_next;
    logic                           deep_reg;
    logic                           deep_next;
    logic                           stale_reg;
    logic                           stale_next;
    logic                           first_reg;
    logic                           first_next;

    logic                           out_valid_reg;
    logic                           out_valid_next;
    logic [W-1:0]                   out_total_reg;
    logic [W-1:0]                   out_total_next;
    logic [W-1:0]                   out_deep_reg;
    logic [W-1:0]                   out_deep_next;
    logic                           out_stale_reg;
    logic                           out_stale_next;
    logic                           out_first_reg;
    logic                           out_first_next;

    plo_pkg::cfg_t                  cfg;
    plo_pkg::sq_ctrl_t              sq_ctrl;
    plo_pkg::sq_ctrl_t              rt_ctrl;
    logic [M-1:0]                   mag_x;
    logic [M-1:0]                   mag_y;
    logic [plo_pkg::SQ_BITS-1:0]    sq_x;
    logic [plo_pkg::SQ_BITS-1:0]    sq_y;
    logic [plo_pkg::SQ_BITS-1:0]    radicand;
    logic [M-1:0]                   root;
    logic [M-1:0]                   step;
    logic [A-1:0]                   path_ext;
    logic [A-1:0]                   deep_ext;
    logic [W-1:0]                   path_sat;
    logic [W-1:0]                   deep_sat;
    logic [T:0]                     age;
    logic                           stale_now;
    logic                           req_take;
    logic                           res_free;

    plo_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    plo_square u_sq_x
    (
        .clk     (clk),
        .ctrl    (sq_ctrl),
        .operand (mag_x),
        .product (sq_x)
    );

    plo_square u_sq_y
    (
        .clk     (clk),
        .ctrl    (sq_ctrl),
        .operand (mag_y),
        .product (sq_y)
    );

    plo_isqrt u_isqrt
    (
        .clk      (clk),
        .ctrl     (rt_ctrl),
        .radicand (radicand),
        .root     (root)
    );

    assign req.ready = (state_reg == ST_IDLE);
    assign req_take  = req.valid && req.ready;
    assign res_free  = !out_valid_reg || res.ready;

    assign mag_x    = dx_reg[M-1] ? (~dx_reg + M'(1)) : dx_reg;
    assign mag_y    = dy_reg[M-1] ? (~dy_reg + M'(1)) : dy_reg;
    assign radicand = sq_x + sq_y;

    assign sq_ctrl.load = (state_reg == ST_LOAD);
    assign sq_ctrl.step = (state_reg == ST_SQUARE);
    assign rt_ctrl.load = (state_reg == ST_RLOAD);
    assign rt_ctrl.step = (state_reg == ST_ROOT);

    assign age       = {1'b0, req.time_now} - {1'b0, req.fix_time};
    assign stale_now = (req.fix_time != '0) && !age[T] && (age[T-1:0] >= cfg.stale_lim);

    assign step     = first_reg ? '0 : root;
    assign path_ext = A'(path_sum_reg) + A'(step);
    assign deep_ext = A'(deep_sum_reg) + A'(step);
    assign path_sat = (|path_ext[A-1:W]) ? '1 : path_ext[W-1:0];
    assign deep_sat = (|deep_ext[A-1:W]) ? '1 : deep_ext[W-1:0];

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        prev_x_next    = prev_x_reg;
        prev_y_next    = prev_y_reg;
        awaiting_next  = awaiting_reg;
        path_sum_next  = path_sum_reg;
        deep_sum_next  = deep_sum_reg;
        dx_next        = dx_reg;
        dy_next        = dy_reg;
        deep_next      = deep_reg;
        stale_next     = stale_reg;
        first_next     = first_reg;
        out_valid_next = out_valid_reg && !res.ready;
        out_total_next = out_total_reg;
        out_deep_next  = out_deep_reg;
        out_stale_next = out_stale_reg;
        out_first_next = out_first_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_take)
                begin
                    dx_next       = M'($signed({req.pos_x[P-1], req.pos_x})
                                      - $signed({prev_x_reg[P-1], prev_x_reg}));
                    dy_next       = M'($signed({req.pos_y[P-1], req.pos_y})
                                      - $signed({prev_y_reg[P-1], prev_y_reg}));
                    deep_next     = req.depth_now > cfg.depth_thr;
                    stale_next    = stale_now;
                    first_next    = awaiting_reg;
                    awaiting_next = 1'b0;
                    prev_x_next   = req.pos_x;
                    prev_y_next   = req.pos_y;
                    state_next    = awaiting_reg ? ST_ACCUM : ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                cnt_next   = plo_pkg::CNT_BITS'(M - 1);
                state_next = ST_SQUARE;
            end
            ST_SQUARE:
            begin
                cnt_next = cnt_reg - plo_pkg::CNT_BITS'(1);
                if (cnt_reg == '0)
                begin
                    state_next = ST_RLOAD;
                end
            end
            ST_RLOAD:
            begin
                cnt_next   = plo_pkg::CNT_BITS'(M - 1);
                state_next = ST_ROOT;
            end
            ST_ROOT:
            begin
                cnt_next = cnt_reg - plo_pkg::CNT_BITS'(1);
                if (cnt_reg == '0)
                begin
                    state_next = ST_ACCUM;
                end
            end
            ST_ACCUM:
            begin
                if (res_free)
                begin
                    path_sum_next  = path_sat;
                    deep_sum_next  = deep_reg ? deep_sat : deep_sum_reg;
                    out_valid_next = 1'b1;
                    out_total_next = path_sat;
                    out_deep_next  = deep_reg ? deep_sat : deep_sum_reg;
                    out_stale_next = stale_reg;
                    out_first_next = first_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            prev_x_reg    <= '0;
            prev_y_reg    <= '0;
            awaiting_reg  <= 1'b1;
            path_sum_reg  <= '0;
            deep_sum_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            prev_x_reg    <= prev_x_next;
            prev_y_reg    <= prev_y_next;
            awaiting_reg  <= awaiting_next;
            path_sum_reg  <= path_sum_next;
            deep_sum_reg  <= deep_sum_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dx_reg        <= dx_next;
        dy_reg        <= dy_next;
        deep_reg      <= deep_next;
        stale_reg     <= stale_next;
        first_reg     <= first_next;
        out_total_reg <= out_total_next;
        out_deep_reg  <= out_deep_next;
        out_stale_reg <= out_stale_next;
        out_first_reg <= out_first_next;
    end

    assign res.valid          = out_valid_reg;
    assign res.total_distance = out_total_reg;
    assign res.depth_distance = out_deep_reg;
    assign res.stale          = out_stale_reg;
    assign res.first_fix      = out_first_reg;

    a_take_starts: assert property (@(posedge clk) disable iff (!rst_n)
        req_take |=> (state_reg == ST_LOAD || state_reg == ST_ACCUM))
        else $error("accepted request did not start work");

    a_square_to_root: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SQUARE && cnt_reg == '0) |=> (state_reg == ST_RLOAD))
        else $error("squaring phase did not hand over to the root");

    a_path_monotone: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (path_sum_reg >= $past(path_sum_reg)))
        else $error("total distance went down");

    a_deep_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        deep_sum_reg <= path_sum_reg)
        else $error("depth distance exceeds total distance");

endmodule
